### rtl/grm_pkg.sv
`timescale 1ns / 1ps

package grm_pkg;

    localparam int CELL_W   = 6;
    localparam int POS_W    = 22;
    localparam int HEAD_W   = 10;
    localparam int DIST_W   = 23;
    localparam int GRID_W   = 7;
    localparam int STEP_W   = 17;
    localparam int TRIG_W   = 15;
    localparam int DELTA_W  = 18;
    localparam int ACC_D_W  = DIST_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 2'd2;

    localparam logic [GRID_W-1:0] RST_GRID_SIZE = 7'd0;
    localparam logic [DIST_W-1:0] RST_MAX_DIST  = 23'd655360;
    localparam logic [STEP_W-1:0] RST_STEP_SIZE = 17'd1311;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q14     = 64'd16384;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    typedef struct packed {
        logic [GRID_W-1:0] grid_size;
        logic [DIST_W-1:0] max_dist;
        logic [STEP_W-1:0] step_size;
    } t_cfg;

    typedef struct packed {
        logic                      op;
        logic [CELL_W-1:0]         cell_x;
        logic [CELL_W-1:0]         cell_y;
        logic                      wall_bit;
        logic [POS_W-1:0]          start_x;
        logic [POS_W-1:0]          start_y;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
    } t_job;

    // quarter-wave sine in Q1.14, integer taylor series in Q30
    function automatic logic [TRIG_W-1:0] sine_q14(input int unsigned k,
                                                   input int unsigned qshift);
        logic [63:0]    x;
        logic [63:0]    t;
        logic [63:0]    v;
        logic signed [63:0] sum;
        x = (64'(k) * HALF_PI_Q30) >> qshift;
        t = x;
        sum = signed'(x);
        for (int n = 1; n <= 6; n++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / TAYLOR_DIV[n-1];
            if ((n % 2) == 1) begin
                sum = sum - signed'(t);
            end else begin
                sum = sum + signed'(t);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (unsigned'(sum) + 64'd32768) >> 16;
        if (v > ONE_Q14) begin
            v = ONE_Q14;
        end
        return v[TRIG_W-1:0];
    endfunction

endpackage

### rtl/grm_in_if.sv
`timescale 1ns / 1ps

interface grm_in_if;
    import grm_pkg::*;

    logic              valid;
    logic              ready;
    logic              op;
    logic [CELL_W-1:0] cell_x;
    logic [CELL_W-1:0] cell_y;
    logic              wall_bit;
    logic [POS_W-1:0]  start_x;
    logic [POS_W-1:0]  start_y;
    logic [HEAD_W-1:0] heading;

    modport source (output valid, op, cell_x, cell_y, wall_bit, start_x, start_y, heading,
                    input ready);
    modport sink (input valid, op, cell_x, cell_y, wall_bit, start_x, start_y, heading,
                  output ready);
endinterface

### rtl/grm_out_if.sv
`timescale 1ns / 1ps

interface grm_out_if;
    import grm_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              hit;

    modport source (output valid, distance, hit, input ready);
    modport sink (input valid, distance, hit, output ready);
endinterface

### rtl/grid_ray_march_unit.sv
`timescale 1ns / 1ps

// Ray marcher over a square wall bitmap. An op-0 beat writes one cell and gives no result;
// an op-1 beat marches a ray from (start_x, start_y) at the given heading in fixed steps
// of step_size and returns the distance to the first wall cell, or max_distance with hit
// low. The march pipeline tests one step per cycle against a single memory read port, so
// a cast tests at most min(MAX_STEPS, ceil(max_distance / step_size)) steps; a front
// stage looks up sine/cosine and scales the step while the previous cast is still
// marching. After reset the wall memory is swept clear, one cell per cycle, over
// 4^ceil(log2(GRID_MAX)) cells (4096 by default); input beats are held off until then,
// while register writes are taken at any time.
module grid_ray_march_unit #(
    parameter int GRID_MAX   = 64,
    parameter int MAX_STEPS  = 4096,
    parameter int ANGLE_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [grm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [grm_pkg::DIST_W-1:0]    i_cfg_data,
    grm_in_if.sink                        i_req,
    grm_out_if.source                     o_res
);
    import grm_pkg::*;

    t_cfg r_cfg;
    logic w_push;
    t_job w_push_job;
    logic w_full;
    logic w_q_valid;
    t_job w_q_job;
    logic w_pop;
    logic w_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_size <= RST_GRID_SIZE;
            r_cfg.max_dist  <= RST_MAX_DIST;
            r_cfg.step_size <= RST_STEP_SIZE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_SIZE: r_cfg.grid_size <= i_cfg_data[GRID_W-1:0];
                CFG_MAX_DIST:  r_cfg.max_dist  <= i_cfg_data;
                CFG_STEP_SIZE: r_cfg.step_size <= i_cfg_data[STEP_W-1:0];
                default:       r_cfg <= r_cfg;
            endcase
        end
    end

    grm_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step_size (r_cfg.step_size),
        .i_hold      (w_clearing),
        .i_req       (i_req),
        .o_push      (w_push),
        .o_job       (w_push_job),
        .i_full      (w_full)
    );

    grm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_job),
        .i_pop   (w_pop)
    );

    grm_march #(
        .GRID_MAX  (GRID_MAX),
        .MAX_STEPS (MAX_STEPS)
    ) u_march (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (w_q_valid),
        .i_q_job    (w_q_job),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_res      (o_res)
    );

endmodule

### rtl/grm_front.sv
`timescale 1ns / 1ps

module grm_front #(
    parameter int ANGLE_BITS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [grm_pkg::STEP_W-1:0]   i_step_size,
    input  logic                         i_hold,
    grm_in_if.sink                       i_req,
    output logic                         o_push,
    output grm_pkg::t_job                o_job,
    input  logic                         i_full
);
    import grm_pkg::*;

    localparam int QTR_SHIFT = ANGLE_BITS - 2;
    localparam int QTR_LEN   = 1 << QTR_SHIFT;
    localparam int TIX_W     = ANGLE_BITS - 1;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_TRIG = 2'd1;
    localparam logic [1:0] F_MUL  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]              r_st;
    logic [1:0]              n_st;
    t_job                    r_job;
    logic [HEAD_W-1:0]       r_head;
    logic [TRIG_W-1:0]       r_mag_c;
    logic [TRIG_W-1:0]       r_mag_s;
    logic                    r_neg_c;
    logic                    r_neg_s;

    logic [TRIG_W-1:0]       w_sine [QTR_LEN+1];
    logic [ANGLE_BITS-1:0]   w_ang_s;
    logic [ANGLE_BITS-1:0]   w_ang_c;
    logic [31:0]             w_prod_c;
    logic [31:0]             w_prod_s;
    logic [DELTA_W-1:0]      w_rnd_c;
    logic [DELTA_W-1:0]      w_rnd_s;
    logic                    w_acc;

    for (genvar k = 0; k <= QTR_LEN; k++) begin : g_sine
        assign w_sine[k] = sine_q14(k, QTR_SHIFT);
    end

    function automatic logic [TIX_W-1:0] tab_idx(input logic [ANGLE_BITS-1:0] a);
        logic [TIX_W-1:0] k;
        k = {1'b0, a[ANGLE_BITS-3:0]};
        return a[ANGLE_BITS-2] ? TIX_W'(QTR_LEN) - k : k;
    endfunction

    assign w_ang_s = ANGLE_BITS'(r_head);
    assign w_ang_c = w_ang_s + ANGLE_BITS'(QTR_LEN);

    assign w_prod_c = 32'(r_mag_c) * 32'(i_step_size) + 32'd8192;
    assign w_prod_s = 32'(r_mag_s) * 32'(i_step_size) + 32'd8192;
    assign w_rnd_c  = w_prod_c[14 +: DELTA_W];
    assign w_rnd_s  = w_prod_s[14 +: DELTA_W];

    assign i_req.ready = (r_st == F_IDLE) && !i_hold;
    assign w_acc       = i_req.valid && i_req.ready;
    assign o_push      = (r_st == F_PUSH);
    assign o_job       = r_job;

    always_comb begin
        n_st = r_st;
        case (r_st)
            F_IDLE: begin
                if (w_acc) begin
                    n_st = (i_req.op == OP_CAST) ? F_TRIG : F_PUSH;
                end
            end
            F_TRIG: n_st = F_MUL;
            F_MUL:  n_st = F_PUSH;
            F_PUSH: begin
                if (!i_full) begin
                    n_st = F_IDLE;
                end
            end
            default: n_st = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= F_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_job.op       <= i_req.op;
            r_job.cell_x   <= i_req.cell_x;
            r_job.cell_y   <= i_req.cell_y;
            r_job.wall_bit <= i_req.wall_bit;
            r_job.start_x  <= i_req.start_x;
            r_job.start_y  <= i_req.start_y;
            r_job.dx       <= '0;
            r_job.dy       <= '0;
            r_head         <= i_req.heading;
        end
        if (r_st == F_TRIG) begin
            r_mag_c <= w_sine[tab_idx(w_ang_c)];
            r_mag_s <= w_sine[tab_idx(w_ang_s)];
            r_neg_c <= w_ang_c[ANGLE_BITS-1];
            r_neg_s <= w_ang_s[ANGLE_BITS-1];
        end
        if (r_st == F_MUL) begin
            r_job.dx <= r_neg_c ? -signed'(w_rnd_c) : signed'(w_rnd_c);
            r_job.dy <= r_neg_s ? -signed'(w_rnd_s) : signed'(w_rnd_s);
        end
    end

endmodule

### rtl/grm_queue.sv
`timescale 1ns / 1ps

module grm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  grm_pkg::t_job i_data,
    output logic          o_full,
    output logic          o_valid,
    output grm_pkg::t_job o_data,
    input  logic          i_pop
);
    import grm_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_count;
    logic            w_wr;
    logic            w_rd;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### rtl/grm_march.sv
`timescale 1ns / 1ps

module grm_march #(
    parameter int GRID_MAX  = 64,
    parameter int MAX_STEPS = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  grm_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  grm_pkg::t_job i_q_job,
    output logic          o_pop,
    output logic          o_clearing,
    grm_out_if.source     o_res
);
    import grm_pkg::*;

    localparam int CW   = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
    localparam int AW   = 2 * CW;
    localparam int MD   = 1 << AW;
    localparam int LMW  = $clog2(GRID_MAX + 1);
    localparam int PW   = $clog2(MAX_STEPS) + 21;
    localparam int HW   = PW - 16;
    localparam int CNTW = $clog2(MAX_STEPS + 1);

    localparam logic [1:0] B_CLEAR = 2'd0;
    localparam logic [1:0] B_IDLE  = 2'd1;
    localparam logic [1:0] B_RUN   = 2'd2;
    localparam logic [1:0] B_DONE  = 2'd3;

    logic                 r_mem [MD];
    logic                 r_rd;
    logic [1:0]           r_st;
    logic [AW-1:0]        r_clr_addr;
    logic                 r_gen;
    logic                 r_b_valid;
    logic                 r_b_out;
    logic [ACC_D_W-1:0]   r_b_d;
    logic signed [PW-1:0] r_px;
    logic signed [PW-1:0] r_py;
    logic signed [DELTA_W-1:0] r_dx;
    logic signed [DELTA_W-1:0] r_dy;
    logic [ACC_D_W-1:0]   r_d;
    logic [CNTW-1:0]      r_cnt;
    logic [DIST_W-1:0]    r_fin_d;
    logic                 r_fin_hit;
    logic                 r_ovalid;
    logic [DIST_W-1:0]    r_odist;
    logic                 r_ohit;

    logic [LMW-1:0]       w_lim;
    logic signed [PW-1:0] w_nx;
    logic signed [PW-1:0] w_ny;
    logic                 w_in;
    logic [AW-1:0]        w_raddr;
    logic                 w_stop;
    logic                 w_issue;
    logic                 w_hit;
    logic                 w_pop_wr;
    logic                 w_pop_cast;
    logic                 w_cell_ok;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic                 w_wdata;
    logic                 w_out_free;

    function automatic logic cell_in(input logic signed [PW-1:0] p,
                                     input logic [LMW-1:0] lim);
        logic [HW-1:0] hi;
        hi = p[PW-1:16];
        if (p[PW-1]) begin
            return (&hi) && (p[15:0] != 16'd0) && (lim != '0);
        end
        return hi < HW'(lim);
    endfunction

    function automatic logic [CW-1:0] cell_idx(input logic signed [PW-1:0] p);
        logic [HW-1:0] hi;
        hi = p[PW-1:16];
        return p[PW-1] ? '0 : hi[CW-1:0];
    endfunction

    assign w_lim = (int'(i_cfg.grid_size) > GRID_MAX) ? LMW'(GRID_MAX)
                                                      : LMW'(i_cfg.grid_size);

    // address stage: next position and its cell
    assign w_nx    = r_px + PW'(r_dx);
    assign w_ny    = r_py + PW'(r_dy);
    assign w_in    = cell_in(w_nx, w_lim) && cell_in(w_ny, w_lim);
    assign w_raddr = {cell_idx(w_ny), cell_idx(w_nx)};
    assign w_stop  = (r_cnt == CNTW'(MAX_STEPS)) || (r_d >= ACC_D_W'(i_cfg.max_dist));
    assign w_issue = (r_st == B_RUN) && r_gen && !w_stop;

    // test stage
    assign w_hit = r_b_valid && (r_b_out || r_rd);

    assign o_pop      = (r_st == B_IDLE) && i_q_valid;
    assign w_pop_wr   = o_pop && (i_q_job.op == OP_WRITE);
    assign w_pop_cast = o_pop && (i_q_job.op == OP_CAST);
    assign w_cell_ok  = (int'(i_q_job.cell_x) < GRID_MAX) && (int'(i_q_job.cell_y) < GRID_MAX);
    assign w_we       = (r_st == B_CLEAR) || (w_pop_wr && w_cell_ok);
    assign w_waddr    = (r_st == B_CLEAR) ? r_clr_addr
                                          : {CW'(i_q_job.cell_y), CW'(i_q_job.cell_x)};
    assign w_wdata    = (r_st == B_CLEAR) ? 1'b0 : i_q_job.wall_bit;
    assign o_clearing = (r_st == B_CLEAR);

    assign w_out_free   = !r_ovalid || o_res.ready;
    assign o_res.valid    = r_ovalid;
    assign o_res.distance = r_odist;
    assign o_res.hit      = r_ohit;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= B_CLEAR;
            r_clr_addr <= '0;
            r_gen      <= 1'b0;
            r_b_valid  <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            case (r_st)
                B_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(MD - 1)) begin
                        r_st <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (w_pop_cast) begin
                        r_gen     <= 1'b1;
                        r_b_valid <= 1'b0;
                        r_st      <= B_RUN;
                    end
                end
                B_RUN: begin
                    if (w_hit || (!r_gen && !r_b_valid)) begin
                        r_gen     <= 1'b0;
                        r_b_valid <= 1'b0;
                        r_st      <= B_DONE;
                    end else begin
                        r_b_valid <= w_issue;
                        if (w_stop) begin
                            r_gen <= 1'b0;
                        end
                    end
                end
                B_DONE: begin
                    if (w_out_free) begin
                        r_st <= B_IDLE;
                    end
                end
                default: r_st <= B_IDLE;
            endcase
            if ((r_st == B_DONE) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop_cast) begin
            r_px  <= signed'(PW'(i_q_job.start_x));
            r_py  <= signed'(PW'(i_q_job.start_y));
            r_dx  <= i_q_job.dx;
            r_dy  <= i_q_job.dy;
            r_d   <= '0;
            r_cnt <= '0;
        end
        if (w_issue) begin
            r_px    <= w_nx;
            r_py    <= w_ny;
            r_d     <= r_d + ACC_D_W'(i_cfg.step_size);
            r_cnt   <= r_cnt + 1'b1;
            r_b_d   <= r_d;
            r_b_out <= !w_in;
        end
        if (r_st == B_RUN) begin
            if (w_hit) begin
                r_fin_d   <= r_b_d[DIST_W-1:0];
                r_fin_hit <= 1'b1;
            end else begin
                r_fin_d   <= i_cfg.max_dist;
                r_fin_hit <= 1'b0;
            end
        end
        if ((r_st == B_DONE) && w_out_free) begin
            r_odist <= r_fin_d;
            r_ohit  <= r_fin_hit;
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import grm_pkg::*;

    localparam int GRID_MAX       = 64;
    localparam int MAX_STEPS      = 4096;
    localparam int ANGLE_BITS     = 10;
    localparam int QTR_SHIFT      = ANGLE_BITS - 2;
    localparam int QTR_LEN        = 1 << QTR_SHIFT;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int RAND_PHASES    = 4;
    localparam int PHASE_BEATS    = 30;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int Q16_ONE        = 65536;
    localparam int Q16_HALF       = 32768;

    typedef struct packed {
        logic              op;
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic              wall_bit;
        logic [POS_W-1:0]  start_x;
        logic [POS_W-1:0]  start_y;
        logic [HEAD_W-1:0] heading;
    } grid_req_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              hit;
    } sighting_t;

    class ray_scoreboard;
        bit                wall_map [GRID_MAX*GRID_MAX];
        logic [GRID_W-1:0] grid_size;
        logic [DIST_W-1:0] view_dist;
        logic [STEP_W-1:0] step_len;
        int                sine_tab [QTR_LEN+1];
        sighting_t         expected_q [$];
        int                errors;
        int                cell_writes;
        int                casts;
        int                hits;
        int                misses;
        int                reg_writes;

        function new();
            longint unsigned x;
            longint unsigned t;
            longint unsigned v;
            longint          acc;
            grid_size = RST_GRID_SIZE;
            view_dist = RST_MAX_DIST;
            step_len  = RST_STEP_SIZE;
            // quarter-wave sine, q30 taylor series rounded to q14
            for (int k = 0; k <= QTR_LEN; k++) begin
                x = k;
                x = (x * HALF_PI_Q30) >> QTR_SHIFT;
                t = x;
                acc = longint'(x);
                for (int n = 1; n <= 6; n++) begin
                    t = (t * x) >> 30;
                    t = (t * x) >> 30;
                    t = t / ((2 * n) * (2 * n + 1));
                    if (n % 2) begin
                        acc = acc - longint'(t);
                    end else begin
                        acc = acc + longint'(t);
                    end
                end
                if (acc < 0) begin
                    acc = 0;
                end
                v = (acc + 32768) >> 16;
                if (v > ONE_Q14) begin
                    v = ONE_Q14;
                end
                sine_tab[k] = int'(v);
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] data);
            reg_writes++;
            case (idx)
                CFG_GRID_SIZE: grid_size = data[GRID_W-1:0];
                CFG_MAX_DIST:  view_dist = data;
                CFG_STEP_SIZE: step_len  = data[STEP_W-1:0];
                default: ;
            endcase
        endfunction

        function int trig(int unsigned angle);
            int unsigned idx;
            int unsigned quad;
            int unsigned k;
            int          mag;
            idx  = angle & ((1 << ANGLE_BITS) - 1);
            quad = (idx >> QTR_SHIFT) & 3;
            k    = idx & (QTR_LEN - 1);
            mag  = (quad & 1) ? sine_tab[QTR_LEN - k] : sine_tab[k];
            return (quad & 2) ? -mag : mag;
        endfunction

        function longint scaled_delta(int t);
            longint m;
            longint v;
            m = (t < 0) ? -t : t;
            v = (m * longint'(step_len) + 8192) >>> 14;
            return (t < 0) ? -v : v;
        endfunction

        // truncation toward zero: (-1, 0) still lands in cell 0
        function int cell_index(longint p, int lim);
            longint c;
            if (p < 0) begin
                if (((-p) >>> 16) != 0) begin
                    return -1;
                end
                c = 0;
            end else begin
                c = p >>> 16;
            end
            if (c >= lim) begin
                return -1;
            end
            return int'(c);
        endfunction

        function bit blocked(longint px, longint py, int lim);
            int cx;
            int cy;
            cx = cell_index(px, lim);
            cy = cell_index(py, lim);
            if (cx < 0 || cy < 0) begin
                return 1'b1;
            end
            return wall_map[cy * GRID_MAX + cx];
        endfunction

        function sighting_t march(grid_req_t r);
            longint    px;
            longint    py;
            longint    dx;
            longint    dy;
            longint    d;
            int        lim;
            sighting_t s;
            lim = (grid_size > GRID_MAX) ? GRID_MAX : int'(grid_size);
            px  = longint'(r.start_x);
            py  = longint'(r.start_y);
            dx  = scaled_delta(trig(int'(r.heading) + QTR_LEN));
            dy  = scaled_delta(trig(int'(r.heading)));
            d   = 0;
            for (int i = 0; i < MAX_STEPS; i++) begin
                if (d >= longint'(view_dist)) begin
                    break;
                end
                px += dx;
                py += dy;
                if (blocked(px, py, lim)) begin
                    s.distance = d[DIST_W-1:0];
                    s.hit      = 1'b1;
                    return s;
                end
                d += longint'(step_len);
            end
            s.distance = view_dist;
            s.hit      = 1'b0;
            return s;
        endfunction

        function void note_beat(grid_req_t r);
            if (r.op == OP_WRITE) begin
                cell_writes++;
                if (r.cell_x < GRID_MAX && r.cell_y < GRID_MAX) begin
                    wall_map[r.cell_y * GRID_MAX + r.cell_x] = r.wall_bit;
                end
            end else begin
                casts++;
                expected_q.push_back(march(r));
            end
        endfunction

        function void check_result(logic [DIST_W-1:0] distance, logic hit);
            sighting_t want;
            if (expected_q.size() == 0) begin
                $error("result beat with no cast pending: distance %0d hit %0d", distance, hit);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (want.hit) begin
                hits++;
            end else begin
                misses++;
            end
            if (distance !== want.distance) begin
                $error("distance: expected %0d, got %0d", want.distance, distance);
                errors++;
            end
            if (hit !== want.hit) begin
                $error("hit: expected %0d, got %0d", want.hit, hit);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [DIST_W-1:0]    i_cfg_data;
    bit                   steady;
    int                   quiet;
    ray_scoreboard        board;

    grm_in_if  req_if ();
    grm_out_if res_if ();

    grid_ray_march_unit #(
        .GRID_MAX  (GRID_MAX),
        .MAX_STEPS (MAX_STEPS),
        .ANGLE_BITS(ANGLE_BITS)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_req     (req_if),
        .o_res     (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready <= steady || ($urandom_range(99) >= 34);
        end
    end

    always @(posedge i_clk) begin
        if (res_if.valid && res_if.ready) begin
            board.check_result(res_if.distance, res_if.hit);
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_beat(input grid_req_t r);
        while (!steady && $urandom_range(99) < 34) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.op       <= r.op;
        req_if.cell_x   <= r.cell_x;
        req_if.cell_y   <= r.cell_y;
        req_if.wall_bit <= r.wall_bit;
        req_if.start_x  <= r.start_x;
        req_if.start_y  <= r.start_y;
        req_if.heading  <= r.heading;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        board.note_beat(r);
        @(negedge i_clk);
    endtask

    // config enable stays high across back-to-back writes, lowered by end_writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        board.set_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic settle();
        req_if.valid <= 1'b0;
        while (board.expected_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_regs(input int grid, input int view, input int step);
        write_reg(CFG_GRID_SIZE, DIST_W'(grid));
        write_reg(CFG_MAX_DIST, DIST_W'(view));
        write_reg(CFG_STEP_SIZE, DIST_W'(step));
        end_writes();
    endtask

    function automatic grid_req_t cell_beat(int cx, int cy, bit wall);
        grid_req_t r;
        r          = '0;
        r.op       = OP_WRITE;
        r.cell_x   = CELL_W'(cx);
        r.cell_y   = CELL_W'(cy);
        r.wall_bit = wall;
        return r;
    endfunction

    function automatic grid_req_t cast_beat(int sx, int sy, int hd);
        grid_req_t r;
        r         = '0;
        r.op      = OP_CAST;
        r.start_x = POS_W'(sx);
        r.start_y = POS_W'(sy);
        r.heading = HEAD_W'(hd);
        return r;
    endfunction

    function automatic grid_req_t random_beat(int span);
        grid_req_t r;
        r.op       = ($urandom_range(99) < 40) ? OP_WRITE : OP_CAST;
        r.cell_x   = CELL_W'($urandom_range(63));
        r.cell_y   = CELL_W'($urandom_range(63));
        r.wall_bit = ($urandom_range(99) < 30);
        r.start_x  = POS_W'($urandom);
        r.start_y  = POS_W'($urandom);
        r.heading  = HEAD_W'($urandom);
        // mostly stay inside the grid in use so rays travel before hitting
        if (span > 0 && $urandom_range(99) < 85) begin
            if (r.op == OP_WRITE) begin
                r.cell_x = CELL_W'($urandom_range(span - 1));
                r.cell_y = CELL_W'($urandom_range(span - 1));
            end else begin
                r.start_x = POS_W'($urandom_range(span * Q16_ONE - 1));
                r.start_y = POS_W'($urandom_range(span * Q16_ONE - 1));
            end
        end
        return r;
    endfunction

    task automatic random_regs();
        int     grid;
        int     step;
        longint view;
        case ($urandom_range(9))
            0:       grid = $urandom_range(65, 127);
            1:       grid = $urandom_range(1);
            default: grid = $urandom_range(2, 64);
        endcase
        if ($urandom_range(3) == 0) begin
            step = $urandom_range(1, 255);
            view = longint'(step) * $urandom_range(1, 1500);
        end else begin
            step = $urandom_range(256, 65535);
            view = longint'(step) * $urandom_range(1, 600);
        end
        if (view > 4194304) begin
            view = 4194304;
        end
        load_regs(grid, int'(view), step);
    endtask

    initial begin
        int span;
        board           = new();
        steady          = 1'b0;
        quiet           = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_GRID_SIZE;
        i_cfg_data      = '0;
        req_if.valid    = 1'b0;
        req_if.op       = OP_WRITE;
        req_if.cell_x   = '0;
        req_if.cell_y   = '0;
        req_if.wall_bit = 1'b0;
        req_if.start_x  = '0;
        req_if.start_y  = '0;
        req_if.heading  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty grid: everything is wall
        send_beat(cast_beat(2 * Q16_ONE, 2 * Q16_ONE, 0));
        settle();
        write_reg(CFG_UNUSED, '1);
        write_reg(CFG_GRID_SIZE, 16);
        end_writes();

        send_beat(cell_beat(0, 0, 1'b1));
        send_beat(cell_beat(63, 63, 1'b1));
        send_beat(cell_beat(8, 8, 1'b1));
        send_beat(cell_beat(0, 63, 1'b0));
        send_beat(cell_beat(63, 0, 1'b1));
        send_beat(cast_beat(4 * Q16_ONE + Q16_HALF, 8 * Q16_ONE + Q16_HALF, 0));
        send_beat(cast_beat(8 * Q16_ONE + Q16_HALF, 4 * Q16_ONE + Q16_HALF, 256));
        send_beat(cast_beat(12 * Q16_ONE + Q16_HALF, 8 * Q16_ONE + Q16_HALF, 512));
        send_beat(cast_beat(8 * Q16_ONE + Q16_HALF, 12 * Q16_ONE + Q16_HALF, 768));
        send_beat(cast_beat(19661, 5 * Q16_ONE + Q16_HALF, 512));
        send_beat(cast_beat(4194303, 4194303, 1023));
        send_beat(cast_beat(Q16_HALF, Q16_HALF, 0));
        send_beat(cast_beat(2 * Q16_ONE + Q16_HALF, 2 * Q16_ONE + Q16_HALF, 128));
        settle();

        // oversized grid, zero view distance, then longest reach at the widest step
        load_regs(127, 0, 65536);
        send_beat(cast_beat(Q16_ONE, Q16_ONE, 0));
        settle();
        load_regs(127, 4194304, 65536);
        send_beat(cast_beat(62 * Q16_ONE + Q16_HALF, 63 * Q16_ONE + Q16_HALF, 0));
        send_beat(cast_beat(Q16_HALF, 30 * Q16_ONE + Q16_HALF, 0));
        settle();

        // zero step marches in place
        load_regs(64, 655360, 0);
        send_beat(cast_beat(10 * Q16_ONE + Q16_HALF, 10 * Q16_ONE + Q16_HALF, 300));
        send_beat(cast_beat(Q16_HALF, Q16_HALF, 0));
        send_beat(cell_beat(0, 0, 1'b0));
        send_beat(cast_beat(Q16_HALF, Q16_HALF, 640));
        settle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            random_regs();
            steady = (p == 1);
            span = (board.grid_size > GRID_MAX) ? GRID_MAX : int'(board.grid_size);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                send_beat(random_beat(span));
            end
            settle();
        end

        $display("%0d cell writes, %0d casts (%0d hits, %0d misses), %0d register writes",
                 board.cell_writes, board.casts, board.hits, board.misses, board.reg_writes);
        $display("grids from empty to oversized, zero step and zero view distance, stalls on both sides");
        if (board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
